### rtl/slkv_pkg.sv
// Shared types, constants and command codes for the skip-list key-value store.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package slkv_pkg;

  localparam int CAPACITY = 1024;
  localparam int LEVELS   = 16;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 64;

  localparam int NODE_AW = $clog2(CAPACITY);
  localparam int IDX_W   = $clog2(CAPACITY + 2);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int LINK_AW = NODE_AW + LVL_W;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  localparam logic [IDX_W-1:0] HEAD_IX  = IDX_W'(CAPACITY);
  localparam logic [IDX_W-1:0] TAIL_IX  = IDX_W'(CAPACITY + 1);
  localparam logic [KEY_W-1:0] TAIL_KEY = {KEY_W{1'b1}};
  localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
  localparam logic [31:0] LFSR_TAPS = 32'h80200003;
  localparam logic [7:0]  THR_RESET = 8'd64;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_MISSING = 2'd1,
    ST_NEW     = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value_out;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LINK_RD,
    OP_KEY_RD,
    OP_STEP,
    OP_VAL_RD,
    OP_VAL_WR,
    OP_DRAW,
    OP_ALLOC,
    OP_NODE_WR,
    OP_LINK_NEW,
    OP_LINK_PREV,
    OP_DEL_RD,
    OP_DEL_WR,
    OP_PUSH,
    OP_SHRINK
  } op_e;

  typedef struct packed {
    op_e     op;
    logic    result;
    status_e st;
    logic    with_val;
  } dp_cmd_t;

  typedef struct packed {
    logic       req_ok;
    logic [1:0] mode;
    logic       lt;
    logic       lvl_zero;
    logic       hit;
    logic       full;
    logic       draw_up;
    logic       h_cap;
    logic       i_eq_h;
    logic       del_go;
    logic       shrink;
    logic       out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/slkv_dp.sv
// Datapath: node memories, link memory, free stack, walk registers, LFSR, result register.
// Depends on slkv_pkg; driven by slkv_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module slkv_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire slkv_pkg::in_t  in_data_i,
  input  wire                 cfg_we_i,
  input  wire [7:0]           cfg_wdata_i,
  input  wire                 out_stall_i,
  input  wire slkv_pkg::dp_cmd_t cmd_i,
  output slkv_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  output slkv_pkg::out_t      out_data_o
);
  import slkv_pkg::*;

  // memories (pool nodes only; head links live in flops, tail is implicit)
  logic [KEY_W-1:0] key_mem  [CAPACITY];
  logic [VAL_W-1:0] val_mem  [CAPACITY];
  logic [IDX_W-1:0] link_mem [2**LINK_AW];
  logic [IDX_W-1:0] stk_mem  [CAPACITY];

  logic [IDX_W-1:0] head_q [LEVELS];
  logic [LEVELS-1:0] nonempty_q;
  logic [IDX_W-1:0] prev_q [LEVELS];
  logic [IDX_W-1:0] succ_q [LEVELS];

  logic [1:0]       mode_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [IDX_W-1:0] x_q, nx_q, n_q, stk_rd_q, hval_q, link_rd_q;
  logic [LVL_W-1:0] lvl_q, top_q, h_q;
  logic [LVL_W:0]   i_q;
  logic [KEY_W-1:0] key_rd_q;
  logic [VAL_W-1:0] val_rd_q;
  logic             hsel_q, eq_q, popped_q;
  logic [CNT_W-1:0] sp_q, fresh_q;
  logic [NODE_AW-1:0] fresh_ix_q;
  logic [31:0]      lfsr_q, lfsr_d;
  logic [7:0]       thr_q;
  out_t             out_q;
  logic             out_valid_q;

  logic [IDX_W-1:0] nx, n_new, succ0;
  logic [KEY_W-1:0] nx_key;
  logic [LVL_W-1:0] ix;
  logic             link_we;
  logic [LINK_AW-1:0] link_wa, link_ra;
  logic [IDX_W-1:0] link_wd;

  function automatic logic [31:0] lfsr8(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    end
    return v;
  endfunction

  assign ix     = i_q[LVL_W-1:0];
  assign succ0  = succ_q[0];
  assign nx     = hsel_q ? hval_q : link_rd_q;
  assign nx_key = (nx_q == TAIL_IX) ? TAIL_KEY : key_rd_q;
  assign n_new  = popped_q ? stk_rd_q : IDX_W'(fresh_ix_q);
  assign lfsr_d = lfsr8(lfsr_q);

  always_comb begin
    link_ra = (cmd_i.op == OP_DEL_RD) ? {succ0[NODE_AW-1:0], ix}
                                      : {x_q[NODE_AW-1:0], lvl_q};
    link_we = 1'b0;
    link_wa = {n_q[NODE_AW-1:0], ix};
    link_wd = succ_q[ix];
    unique case (cmd_i.op)
      OP_LINK_NEW: link_we = 1'b1;
      OP_LINK_PREV: begin
        link_we = (prev_q[ix] != HEAD_IX);
        link_wa = {prev_q[ix][NODE_AW-1:0], ix};
        link_wd = n_q;
      end
      OP_DEL_WR: begin
        link_we = (prev_q[ix] != HEAD_IX);
        link_wa = {prev_q[ix][NODE_AW-1:0], ix};
        link_wd = link_rd_q;
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (cmd_i.op == OP_LINK_RD || cmd_i.op == OP_DEL_RD) link_rd_q <= link_mem[link_ra];
    if (cmd_i.op == OP_NODE_WR) key_mem[n_new[NODE_AW-1:0]] <= key_q;
    if (cmd_i.op == OP_KEY_RD) key_rd_q <= key_mem[nx[NODE_AW-1:0]];
    if (cmd_i.op == OP_NODE_WR) val_mem[n_new[NODE_AW-1:0]] <= val_q;
    else if (cmd_i.op == OP_VAL_WR) val_mem[succ0[NODE_AW-1:0]] <= val_q;
    if (cmd_i.op == OP_VAL_RD) val_rd_q <= val_mem[succ0[NODE_AW-1:0]];
    if (cmd_i.op == OP_PUSH) stk_mem[sp_q[NODE_AW-1:0]] <= succ0;
    if (cmd_i.op == OP_ALLOC) stk_rd_q <= stk_mem[NODE_AW'(sp_q - CNT_W'(1))];
  end

  // walk and payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        mode_q <= in_data_i.mode;
        key_q  <= in_data_i.key;
        val_q  <= in_data_i.value_in;
        x_q    <= HEAD_IX;
        lvl_q  <= top_q;
        h_q    <= '0;
        i_q    <= '0;
      end
      OP_LINK_RD: begin
        hsel_q <= (x_q == HEAD_IX);
        hval_q <= head_q[lvl_q];
      end
      OP_KEY_RD: nx_q <= nx;
      OP_STEP: begin
        if (nx_key < key_q) begin
          x_q <= nx_q;
        end else begin
          prev_q[lvl_q] <= x_q;
          succ_q[lvl_q] <= nx_q;
          eq_q <= (nx_key == key_q);
          if (lvl_q != '0) lvl_q <= lvl_q - LVL_W'(1);
        end
      end
      OP_DRAW: if (lfsr_d[7:0] < thr_q) h_q <= h_q + LVL_W'(1);
      OP_NODE_WR: begin
        n_q <= n_new;
        i_q <= '0;
        for (int l = 0; l < LEVELS; l++) begin
          if (LVL_W'(l) > top_q && LVL_W'(l) <= h_q) begin
            prev_q[l] <= HEAD_IX;
            succ_q[l] <= TAIL_IX;
          end
        end
      end
      OP_LINK_PREV, OP_DEL_WR: i_q <= i_q + (LVL_W+1)'(1);
      default: ;
    endcase
  end

  // control-side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) head_q[l] <= TAIL_IX;
      nonempty_q  <= '0;
      top_q       <= '0;
      sp_q        <= '0;
      fresh_q     <= '0;
      fresh_ix_q  <= '0;
      popped_q    <= 1'b0;
      lfsr_q      <= LFSR_SEED;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      unique case (cmd_i.op)
        OP_DRAW: lfsr_q <= lfsr_d;
        OP_ALLOC: begin
          if (sp_q != '0) begin
            sp_q     <= sp_q - CNT_W'(1);
            popped_q <= 1'b1;
          end else begin
            fresh_ix_q <= fresh_q[NODE_AW-1:0];
            fresh_q    <= fresh_q + CNT_W'(1);
            popped_q   <= 1'b0;
          end
        end
        OP_NODE_WR: if (h_q > top_q) top_q <= h_q;
        OP_LINK_PREV: if (prev_q[ix] == HEAD_IX) begin
          head_q[ix]     <= n_q;
          nonempty_q[ix] <= 1'b1;
        end
        OP_DEL_WR: if (prev_q[ix] == HEAD_IX) begin
          head_q[ix]     <= link_rd_q;
          nonempty_q[ix] <= (link_rd_q != TAIL_IX);
        end
        OP_PUSH: sp_q <= sp_q + CNT_W'(1);
        OP_SHRINK: top_q <= top_q - LVL_W'(1);
        default: ;
      endcase
      if (cmd_i.result) begin
        out_valid_q     <= 1'b1;
        out_q.status    <= cmd_i.st;
        out_q.value_out <= cmd_i.with_val ? val_rd_q : '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.req_ok   = (key_q != TAIL_KEY);
    stat_o.mode     = mode_q;
    stat_o.lt       = (nx_key < key_q);
    stat_o.lvl_zero = (lvl_q == '0);
    stat_o.hit      = eq_q;
    stat_o.full     = (sp_q == '0) && (fresh_q == CNT_W'(CAPACITY));
    stat_o.draw_up  = (lfsr_d[7:0] < thr_q);
    stat_o.h_cap    = (h_q == LVL_W'(LEVELS - 1));
    stat_o.i_eq_h   = (ix == h_q);
    stat_o.del_go   = (i_q <= {1'b0, top_q}) && (succ_q[ix] == succ0);
    stat_o.shrink   = (top_q != '0) && !nonempty_q[top_q];
    stat_o.out_busy = out_valid_q && out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CNT_W'(CAPACITY))
    else $error("allocation count past capacity");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= fresh_q)
    else $error("free stack holds more nodes than were ever allocated");
  a_top_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty_q >> top_q) <= LEVELS'(1))
    else $error("populated level above top level");
endmodule
`default_nettype wire

### rtl/slkv_ctrl.sv
// Controller: sequences walk, insert, delete and result transfer.
// Depends on slkv_pkg; commands slkv_dp through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module slkv_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire slkv_pkg::dp_stat_t stat_i,
  output slkv_pkg::dp_cmd_t     cmd_o
);
  import slkv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LINK, S_KEY, S_STEP, S_DISP, S_VAL, S_DRAW, S_ALLOC,
    S_NODE, S_LNEW, S_LPREV, S_DCHK, S_DWR, S_PUSH, S_SHRINK, S_RESULT
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    wv_q, wv_d;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    wv_d    = wv_q;
    cmd_o   = '{op: OP_NONE, result: 1'b0, st: st_q, with_val: wv_q};
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.op = OP_LOAD;
        state_d  = S_LINK;
      end
      S_LINK: begin
        cmd_o.op = OP_LINK_RD;
        state_d  = S_KEY;
      end
      S_KEY: begin
        cmd_o.op = OP_KEY_RD;
        state_d  = S_STEP;
      end
      S_STEP: begin
        cmd_o.op = OP_STEP;
        state_d  = (stat_i.lt || !stat_i.lvl_zero) ? S_LINK : S_DISP;
      end
      S_DISP: begin
        st_d    = ST_MISSING;
        wv_d    = 1'b0;
        state_d = S_RESULT;
        if (stat_i.req_ok) begin
          priority if (stat_i.mode == MODE_SEARCH) begin
            if (stat_i.hit) state_d = S_VAL;
          end else if (stat_i.mode == MODE_INSERT) begin
            if (stat_i.hit) begin
              cmd_o.op = OP_VAL_WR;
              st_d     = ST_FOUND;
            end else if (stat_i.full) begin
              st_d = ST_FULL;
            end else begin
              state_d = S_DRAW;
            end
          end else if (stat_i.mode == MODE_DELETE) begin
            if (stat_i.hit) state_d = S_DCHK;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_VAL: begin
        cmd_o.op = OP_VAL_RD;
        st_d     = ST_FOUND;
        wv_d     = 1'b1;
        state_d  = S_RESULT;
      end
      S_DRAW: begin
        if (stat_i.h_cap) begin
          state_d = S_ALLOC;
        end else begin
          cmd_o.op = OP_DRAW;
          if (!stat_i.draw_up) state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd_o.op = OP_ALLOC;
        state_d  = S_NODE;
      end
      S_NODE: begin
        cmd_o.op = OP_NODE_WR;
        state_d  = S_LNEW;
      end
      S_LNEW: begin
        cmd_o.op = OP_LINK_NEW;
        state_d  = S_LPREV;
      end
      S_LPREV: begin
        cmd_o.op = OP_LINK_PREV;
        if (stat_i.i_eq_h) begin
          st_d    = ST_NEW;
          state_d = S_RESULT;
        end else begin
          state_d = S_LNEW;
        end
      end
      S_DCHK: begin
        if (stat_i.del_go) begin
          cmd_o.op = OP_DEL_RD;
          state_d  = S_DWR;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_DWR: begin
        cmd_o.op = OP_DEL_WR;
        state_d  = S_DCHK;
      end
      S_PUSH: begin
        cmd_o.op = OP_PUSH;
        state_d  = S_SHRINK;
      end
      S_SHRINK: begin
        if (stat_i.shrink) begin
          cmd_o.op = OP_SHRINK;
        end else begin
          st_d    = ST_FOUND;
          state_d = S_RESULT;
        end
      end
      S_RESULT: if (!stat_i.out_busy) begin
        cmd_o.result = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_MISSING;
      wv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      wv_q    <= wv_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LOAD) |=> in_stall_o)
    else $error("request taken without going busy");
  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result |-> !stat_i.out_busy)
    else $error("result overwrote a waiting transfer");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result |=> !in_stall_o)
    else $error("controller did not return to idle after result");
endmodule
`default_nettype wire

### rtl/skip_list_key_value_store_top.sv
// Top level of the skip-list key-value store: controller plus datapath.
// Depends on slkv_pkg, slkv_ctrl and slkv_dp.
//
// Sorted map of 31-bit keys to 64-bit values in a pool of 1024 nodes, kept as a
// skip list of up to 16 levels. One request at a time: search, insert/update or
// delete; each gives exactly one result transfer (status, value). A request
// walks down from the top level; every link followed or level descended takes
// a link read, a key read and a compare. Every request also passes through
// the input transfer, dispatch and the result transfer, plus any wait on
// out_stall_i. A search hit adds a value read. Insert adds the height draws
// (plus a pass without a draw when the height reaches the cap), allocation
// and write of the node, and a new-link and a previous-link write per level
// linked. Delete adds a check and an unlink write per level unlinked, a shrink
// step per emptied top level, and a final check, free-stack push and shrink
// check. At 1024 keys and the reset threshold a walk makes about 20 compares.
// No clearing pass after reset: head links live in flops and fresh nodes come
// from a counter.
// The next request is taken while a finished result still waits on out_stall_i.
// promote_threshold (reset 64) is written through cfg_we_i / cfg_wdata_i. Write
// it only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module skip_list_key_value_store_top (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire slkv_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output slkv_pkg::out_t       out_data_o,
  input  wire                  cfg_we_i,
  input  wire [7:0]            cfg_wdata_i
);
  import slkv_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  slkv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage and compare
  slkv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );
endmodule
`default_nettype wire
